### rtl/ray_box_focus_point_assert.svh
// Assertion macros used by the checker of the ray box focus point block.
`ifndef RAY_BOX_FOCUS_POINT_ASSERT_SVH
`define RAY_BOX_FOCUS_POINT_ASSERT_SVH

// Same-cycle implication.
`define RBFP_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rbfp check failed");

// Next-cycle implication.
`define RBFP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rbfp check failed");

`endif

### rtl/rbfp_pkg.sv
// ---------------------------------------------------------------------------
// rbfp_pkg
// Widths, status codes, transaction layouts and helpers of the ray box
// focus point block.
// ---------------------------------------------------------------------------
package rbfp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CRD_W     = 32;
   localparam int DIR_W     = 18;
   localparam int EPS_W     = 16;
   localparam int NUM_W     = CRD_W + 1;
   localparam int PRD_W     = NUM_W + DIR_W;
   localparam int DOT_W     = PRD_W + 2;
   localparam int PNT_W     = DIR_W + CRD_W;
   localparam int WIDE_W    = 64;
   localparam int STATUS_W  = 3;
   localparam int REQ_W     = 344;
   localparam int RSP_W     = 104;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int DIV_STEPS = CRD_W;
   localparam int DIV_LAT   = DIV_STEPS + 2;
   localparam int SIDE_DLY  = DIV_LAT - 2;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INV    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISS   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BEHIND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DEGEN  = 3'd4;

   localparam logic signed [CRD_W-1:0] T_INF = {1'b0, {(CRD_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] W_MAX = (64'sd1 <<< (CRD_W-1)) - 64'sd1;
   localparam logic signed [WIDE_W-1:0] W_MIN = -(64'sd1 <<< (CRD_W-1));

   typedef struct packed {
      logic [1:0]              pad;
      logic signed [CRD_W-1:0] box_max_z;
      logic signed [CRD_W-1:0] box_max_y;
      logic signed [CRD_W-1:0] box_max_x;
      logic signed [CRD_W-1:0] box_min_z;
      logic signed [CRD_W-1:0] box_min_y;
      logic signed [CRD_W-1:0] box_min_x;
      logic signed [DIR_W-1:0] dir_z;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [CRD_W-1:0] origin_z;
      logic signed [CRD_W-1:0] origin_y;
      logic signed [CRD_W-1:0] origin_x;
   } rbfp_req_type;

   typedef struct packed {
      logic [4:0]              pad;
      logic [STATUS_W-1:0]     status;
      logic signed [CRD_W-1:0] focus_z;
      logic signed [CRD_W-1:0] focus_y;
      logic signed [CRD_W-1:0] focus_x;
   } rbfp_rsp_type;

   // Per-ray data that travels beside the dividers.
   typedef struct packed {
      logic                        vld;
      logic                        inv;
      logic [2:0]                  par;
      logic [2:0]                  outside;
      logic signed [CRD_W-1:0]     fdist;
      logic [2:0][CRD_W-1:0]       org;
      logic [2:0][DIR_W-1:0]       dir;
   } rbfp_side_type;

   function automatic logic signed [CRD_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] y;
      y = x;
      if (x > W_MAX) y = W_MAX;
      if (x < W_MIN) y = W_MIN;
      return y[CRD_W-1:0];
   endfunction

endpackage

### rtl/rbfp_div.sv
// ---------------------------------------------------------------------------
// rbfp_div
// Pipelined signed divider: ((num << FRAC_BITS) / den), truncated toward
// zero and saturated to 32 bits. One quotient bit per stage.
// ---------------------------------------------------------------------------
module rbfp_div (
   input  logic                                clock,
   input  logic                                adv,
   input  logic signed [rbfp_pkg::NUM_W-1:0]   num,
   input  logic signed [rbfp_pkg::DIR_W-1:0]   den,
   output logic signed [rbfp_pkg::CRD_W-1:0]   quo
);
   import rbfp_pkg::*;

   localparam int REM_W = (NUM_W + FRAC_BITS > DIR_W + DIV_STEPS + 1) ?
                          NUM_W + FRAC_BITS : DIR_W + DIV_STEPS + 1;

   logic [REM_W-1:0]     rem_ff [DIV_STEPS+1];
   logic [REM_W-1:0]     rem_in [DIV_STEPS+1];
   logic [DIR_W-1:0]     den_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_in   [DIV_STEPS+1];
   logic                 neg_ff [DIV_STEPS+1];
   logic                 ovf_ff [DIV_STEPS+1];

   logic [NUM_W-1:0]        num_mag;
   logic [DIR_W-1:0]        den_mag;
   logic                    ovf0;
   logic signed [CRD_W-1:0] quo_ff;
   logic signed [CRD_W-1:0] quo_in;
   logic [REM_W-1:0]        dsh;
   logic                    last_neg;
   logic                    last_sat;

   always_comb begin
      num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_mag = den[DIR_W-1] ? DIR_W'(-den) : DIR_W'(den);
      rem_in[0] = REM_W'(num_mag) << FRAC_BITS;
      q_in[0]   = '0;
      ovf0 = rem_in[0] >= (REM_W'(den_mag) << DIV_STEPS);
      for (int k = 1; k <= DIV_STEPS; k++) begin
         dsh = REM_W'(den_ff[k-1]) << (DIV_STEPS - k);
         rem_in[k] = rem_ff[k-1];
         q_in[k]   = q_ff[k-1];
         if (rem_ff[k-1] >= dsh) begin
            rem_in[k] = rem_ff[k-1] - dsh;
            q_in[k][DIV_STEPS-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         den_ff[0] <= den_mag;
         neg_ff[0] <= num[NUM_W-1] ^ den[DIR_W-1];
         ovf_ff[0] <= ovf0;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
         quo_ff <= quo_in;
      end
   end

   // Apply sign and saturate.
   always_comb begin
      last_neg = neg_ff[DIV_STEPS];
      if (last_neg) begin
         last_sat = ovf_ff[DIV_STEPS] ||
                    (q_ff[DIV_STEPS] > {1'b1, {(DIV_STEPS-1){1'b0}}});
         quo_in = last_sat ? -T_INF - CRD_W'(1) : CRD_W'(-q_ff[DIV_STEPS]);
      end else begin
         last_sat = ovf_ff[DIV_STEPS] || q_ff[DIV_STEPS][DIV_STEPS-1];
         quo_in = last_sat ? T_INF : CRD_W'(q_ff[DIV_STEPS]);
      end
   end

   assign quo = quo_ff;

endmodule

### rtl/rbfp_front.sv
// ---------------------------------------------------------------------------
// rbfp_front
// Front stages: slab numerators, flags, and the projected center distance.
// ---------------------------------------------------------------------------
module rbfp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_vld,
   input  rbfp_pkg::rbfp_req_type             req,
   input  logic [rbfp_pkg::EPS_W-1:0]         peps,
   output logic signed [rbfp_pkg::NUM_W-1:0]  num_lo [3],
   output logic signed [rbfp_pkg::NUM_W-1:0]  num_hi [3],
   output logic signed [rbfp_pkg::DIR_W-1:0]  den [3],
   output rbfp_pkg::rbfp_side_type            side
);
   import rbfp_pkg::*;

   logic signed [CRD_W-1:0] org_w  [3];
   logic signed [CRD_W-1:0] bmin_w [3];
   logic signed [CRD_W-1:0] bmax_w [3];
   logic signed [DIR_W-1:0] dir_w  [3];

   logic signed [NUM_W-1:0] sum_w;
   logic signed [NUM_W-1:0] ctr_w;
   logic [DIR_W-1:0]        mag_w;
   logic [2:0]              inv_w;

   logic signed [NUM_W-1:0] diff_in [3];
   logic signed [NUM_W-1:0] nlo_in  [3];
   logic signed [NUM_W-1:0] nhi_in  [3];
   rbfp_side_type           s1_in;

   logic signed [NUM_W-1:0] s1_diff_ff [3];
   logic signed [NUM_W-1:0] s1_nlo_ff  [3];
   logic signed [NUM_W-1:0] s1_nhi_ff  [3];
   rbfp_side_type           s1_side_ff;

   logic signed [PRD_W-1:0] s2_prod_in [3];
   logic signed [PRD_W-1:0] s2_prod_ff [3];
   rbfp_side_type           s2_side_ff;

   logic signed [DOT_W-1:0] dot_w;
   logic signed [DOT_W-1:0] dsh_w;
   rbfp_side_type           s3_in;
   rbfp_side_type           s3_side_ff;

   assign org_w[0]  = req.origin_x;
   assign org_w[1]  = req.origin_y;
   assign org_w[2]  = req.origin_z;
   assign dir_w[0]  = req.dir_x;
   assign dir_w[1]  = req.dir_y;
   assign dir_w[2]  = req.dir_z;
   assign bmin_w[0] = req.box_min_x;
   assign bmin_w[1] = req.box_min_y;
   assign bmin_w[2] = req.box_min_z;
   assign bmax_w[0] = req.box_max_x;
   assign bmax_w[1] = req.box_max_y;
   assign bmax_w[2] = req.box_max_z;

   always_comb begin
      s1_in = '0;
      s1_in.vld = in_vld;
      for (int a = 0; a < 3; a++) begin
         sum_w = NUM_W'(bmin_w[a]) + NUM_W'(bmax_w[a]);
         ctr_w = sum_w >>> 1;
         diff_in[a] = ctr_w - NUM_W'(org_w[a]);
         nlo_in[a]  = NUM_W'(bmin_w[a]) - NUM_W'(org_w[a]);
         nhi_in[a]  = NUM_W'(bmax_w[a]) - NUM_W'(org_w[a]);
         inv_w[a]   = bmin_w[a] > bmax_w[a];
         mag_w = dir_w[a][DIR_W-1] ? DIR_W'(-dir_w[a]) : DIR_W'(dir_w[a]);
         s1_in.par[a]     = mag_w <= DIR_W'(peps);
         s1_in.outside[a] = (org_w[a] < bmin_w[a]) || (org_w[a] > bmax_w[a]);
         s1_in.org[a]     = org_w[a];
         s1_in.dir[a]     = dir_w[a];
      end
      s1_in.inv = |inv_w;
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s2_prod_in[a] = s1_diff_ff[a] * $signed(s1_side_ff.dir[a]);
      end
   end

   always_comb begin
      dot_w = DOT_W'(s2_prod_ff[0]) + DOT_W'(s2_prod_ff[1]) + DOT_W'(s2_prod_ff[2]);
      dsh_w = dot_w >>> FRAC_BITS;
      s3_in = s2_side_ff;
      s3_in.fdist = sat32(WIDE_W'(dsh_w));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.vld <= 1'b0;
         s2_side_ff.vld <= 1'b0;
         s3_side_ff.vld <= 1'b0;
      end else if (adv) begin
         s1_side_ff <= s1_in;
         s2_side_ff <= s1_side_ff;
         s3_side_ff <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            s1_diff_ff[a] <= diff_in[a];
            s1_nlo_ff[a]  <= nlo_in[a];
            s1_nhi_ff[a]  <= nhi_in[a];
            s2_prod_ff[a] <= s2_prod_in[a];
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         num_lo[a] = s1_nlo_ff[a];
         num_hi[a] = s1_nhi_ff[a];
         den[a]    = $signed(s1_side_ff.dir[a]);
      end
   end

   assign side = s3_side_ff;

endmodule

### rtl/rbfp_back.sv
// ---------------------------------------------------------------------------
// rbfp_back
// Back stages: order and merge slab distances, clamp, status, focus point.
// ---------------------------------------------------------------------------
module rbfp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  rbfp_pkg::rbfp_side_type           side,
   input  logic signed [rbfp_pkg::CRD_W-1:0] t0 [3],
   input  logic signed [rbfp_pkg::CRD_W-1:0] t1 [3],
   input  logic [rbfp_pkg::EPS_W-1:0]        deps,
   output logic                              out_vld,
   output rbfp_pkg::rbfp_rsp_type            out_rsp
);
   import rbfp_pkg::*;

   // Stage 1: order each axis.
   logic signed [CRD_W-1:0] b1_lo_ff [3];
   logic signed [CRD_W-1:0] b1_hi_ff [3];
   rbfp_side_type           b1_side_ff;

   // Stage 2: merge.
   logic signed [CRD_W-1:0] tmin_in, tmax_in;
   logic signed [CRD_W-1:0] b2_tmin_ff, b2_tmax_ff;
   rbfp_side_type           b2_side_ff;

   // Stage 3: status and clamp.
   logic signed [CRD_W-1:0] deps_s;
   logic signed [CRD_W-1:0] lower_w;
   logic signed [CRD_W-1:0] dist_in;
   logic                    miss_w;
   logic [STATUS_W-1:0]     status_in;
   logic [STATUS_W-1:0]     b3_status_ff;
   rbfp_side_type           b3_in;
   rbfp_side_type           b3_side_ff;

   // Stage 4: products.
   logic signed [PNT_W-1:0] b4_prod_ff [3];
   logic [STATUS_W-1:0]     b4_status_ff;
   rbfp_side_type           b4_side_ff;

   // Stage 5: output register.
   logic signed [CRD_W-1:0] foc_in [3];
   logic signed [PNT_W-1:0] psh_w;
   logic                    b5_vld_ff;
   rbfp_rsp_type            b5_rsp_ff;

   always_comb begin
      tmin_in = '0;
      tmax_in = T_INF;
      for (int a = 0; a < 3; a++) begin
         if (!b1_side_ff.par[a]) begin
            if (b1_lo_ff[a] > tmin_in) tmin_in = b1_lo_ff[a];
            if (b1_hi_ff[a] < tmax_in) tmax_in = b1_hi_ff[a];
         end
      end
   end

   always_comb begin
      deps_s  = $signed(CRD_W'(deps));
      miss_w  = (|(b2_side_ff.par & b2_side_ff.outside)) || (b2_tmin_ff > b2_tmax_ff);
      lower_w = (b2_tmin_ff > deps_s) ? b2_tmin_ff : deps_s;
      dist_in = b2_side_ff.fdist;
      if (dist_in < lower_w) dist_in = lower_w;
      if (dist_in > b2_tmax_ff) dist_in = b2_tmax_ff;
      priority if (b2_side_ff.inv) status_in = ST_INV;
      else if (miss_w) status_in = ST_MISS;
      else if (!(b2_tmax_ff > deps_s)) status_in = ST_BEHIND;
      else if (!(dist_in > deps_s)) status_in = ST_DEGEN;
      else status_in = ST_OK;
      b3_in = b2_side_ff;
      b3_in.fdist = dist_in;
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         psh_w = b4_prod_ff[a] >>> FRAC_BITS;
         foc_in[a] = (b4_status_ff == ST_OK) ?
                     sat32(WIDE_W'($signed(b4_side_ff.org[a])) + WIDE_W'(psh_w)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_side_ff.vld <= 1'b0;
         b2_side_ff.vld <= 1'b0;
         b3_side_ff.vld <= 1'b0;
         b4_side_ff.vld <= 1'b0;
         b5_vld_ff      <= 1'b0;
      end else if (adv) begin
         b1_side_ff <= side;
         b2_side_ff <= b1_side_ff;
         b3_side_ff <= b3_in;
         b4_side_ff <= b3_side_ff;
         b5_vld_ff  <= b4_side_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            b1_lo_ff[a] <= (t0[a] > t1[a]) ? t1[a] : t0[a];
            b1_hi_ff[a] <= (t0[a] > t1[a]) ? t0[a] : t1[a];
            b4_prod_ff[a] <= $signed(b3_side_ff.dir[a]) * b3_side_ff.fdist;
         end
         b2_tmin_ff   <= tmin_in;
         b2_tmax_ff   <= tmax_in;
         b3_status_ff <= status_in;
         b4_status_ff <= b3_status_ff;
         b5_rsp_ff.pad     <= '0;
         b5_rsp_ff.status  <= b4_status_ff;
         b5_rsp_ff.focus_x <= foc_in[0];
         b5_rsp_ff.focus_y <= foc_in[1];
         b5_rsp_ff.focus_z <= foc_in[2];
      end
   end

   assign out_vld = b5_vld_ff;
   assign out_rsp = b5_rsp_ff;

endmodule

### rtl/ray_box_focus_point.sv
// ---------------------------------------------------------------------------
// ray_box_focus_point
// Slab test of a ray against an axis-aligned box, then the clamped focus
// point on the ray with a status code.
//
//   channel   direction   fields
//   req_*     in          origin, direction, box corners (344-bit tdata)
//   rsp_*     out         focus point and status (104-bit tdata)
//   csr_*     in/out      parallel_eps at 0x0, distance_eps at 0x4
//
// One ray per cycle while rsp_tready does not hold the pipeline; the slab
// distances come from six pipelined slab dividers running in parallel.
// Reset clears all valid bits and sets parallel_eps to 0, distance_eps to 1.
// With rsp_tready low and a result waiting, the whole pipeline holds and
// req_tready drops; bubbles inside the pipeline hold in place as well.
// ---------------------------------------------------------------------------
module ray_box_focus_point (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_min_x, box_min_y,
   // box_min_z, box_max_x, box_max_y, box_max_z, zero fill
   input  logic [rbfp_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // focus_x, focus_y, focus_z, status, zero fill
   output logic [rbfp_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rbfp_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [rbfp_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [rbfp_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import rbfp_pkg::*;

   logic [EPS_W-1:0] peps_ff;
   logic [EPS_W-1:0] deps_ff;
   logic             csr_wr;
   logic             adv;

   logic signed [NUM_W-1:0] num_lo [3];
   logic signed [NUM_W-1:0] num_hi [3];
   logic signed [DIR_W-1:0] den    [3];
   logic signed [CRD_W-1:0] t0     [3];
   logic signed [CRD_W-1:0] t1     [3];

   rbfp_side_type side_front;
   rbfp_side_type side_dly_ff [SIDE_DLY];
   rbfp_rsp_type  rsp_w;
   logic          rsp_vld;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? CSR_DW'(deps_ff) : CSR_DW'(peps_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         peps_ff <= '0;
         deps_ff <= EPS_W'(1);
      end else if (csr_wr) begin
         if (csr_paddr[2]) deps_ff <= csr_pwdata[EPS_W-1:0];
         else peps_ff <= csr_pwdata[EPS_W-1:0];
      end
   end

   assign adv        = !rsp_vld || rsp_tready;
   assign req_tready = adv;

   rbfp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .in_vld (req_tvalid),
      .req    (rbfp_req_type'(req_tdata)),
      .peps   (peps_ff),
      .num_lo (num_lo),
      .num_hi (num_hi),
      .den    (den),
      .side   (side_front)
   );

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbfp_div u_div_lo (
         .clock (clock),
         .adv   (adv),
         .num   (num_lo[a]),
         .den   (den[a]),
         .quo   (t0[a])
      );
      rbfp_div u_div_hi (
         .clock (clock),
         .adv   (adv),
         .num   (num_hi[a]),
         .den   (den[a]),
         .quo   (t1[a])
      );
   end

   // Hold ray data until the slab quotients come out.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIDE_DLY; k++) side_dly_ff[k].vld <= 1'b0;
      end else if (adv) begin
         side_dly_ff[0] <= side_front;
         for (int k = 1; k < SIDE_DLY; k++) side_dly_ff[k] <= side_dly_ff[k-1];
      end
   end

   rbfp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .side    (side_dly_ff[SIDE_DLY-1]),
      .t0      (t0),
      .t1      (t1),
      .deps    (deps_ff),
      .out_vld (rsp_vld),
      .out_rsp (rsp_w)
   );

   assign rsp_tvalid = rsp_vld;
   assign rsp_tdata  = rsp_w;

endmodule

### rtl/rbfp_check.sv
// ---------------------------------------------------------------------------
// rbfp_check
// Port-level checks of the ray box focus point block, bound to the top.
// ---------------------------------------------------------------------------
`include "ray_box_focus_point_assert.svh"

module rbfp_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [rbfp_pkg::RSP_W-1:0] rsp_tdata
);
   import rbfp_pkg::*;

   `RBFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `RBFP_ASSERT_SAME(a_err_zero, clock, reset, rsp_tvalid && (rsp_tdata[98:96] != ST_OK), rsp_tdata[95:0] == '0)
   `RBFP_ASSERT_SAME(a_stall_link, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))
   `RBFP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind ray_box_focus_point rbfp_check u_check (.*);

### tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Ray against axis-aligned box, focus point and status.
// A directed table of rays covers the corner cases, then random rays, each of
// them against a random box, run under random gaps on both channels. Every
// result is compared with an in-bench computation of the slab test and clamp.
// The two epsilon registers are changed between phases while the pipe is empty.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rbfp_pkg::*;

   localparam int RANDOM_RAYS = 800;
   localparam int LIMIT       = 400000;
   localparam int PIPE_LAT    = 40;
   localparam logic [CSR_AW-1:0] ADDR_PAR_EPS  = 3'd0;
   localparam logic [CSR_AW-1:0] ADDR_DIST_EPS = 3'd4;
   localparam logic [2:0] NO_CHECK = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   ray_box_focus_point u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [15:0] par_eps, dist_eps;
   rbfp_rsp_type focus_q[$];
   logic [2:0] typed_q[$];
   int errors = 0;
   int cycles = 0;
   bit feeding = 1'b1;

   function automatic longint fl_shr(longint x, int n);
      return x >>> n;
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic rbfp_rsp_type focus_of(rbfp_req_type r);
      rbfp_rsp_type res;
      longint o[3], d[3], lo[3], hi[3];
      longint dot, tmin, tmax, fdist, lower, t0, t1, t, mag, deps, peps;
      logic [2:0] st;
      res = '0;
      o = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
      d = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
      lo = '{longint'(r.box_min_x), longint'(r.box_min_y), longint'(r.box_min_z)};
      hi = '{longint'(r.box_max_x), longint'(r.box_max_y), longint'(r.box_max_z)};
      deps = longint'(dist_eps);
      peps = longint'(par_eps);
      st = ST_OK;
      dot = 0; tmin = 0; tmax = 64'sd2147483647;
      for (int a = 0; a < 3; a++) if (lo[a] > hi[a]) st = ST_INV;
      if (st == ST_OK) begin
         for (int a = 0; a < 3; a++) dot += (fl_shr(lo[a] + hi[a], 1) - o[a]) * d[a];
         fdist = clip32(fl_shr(dot, FRAC_BITS));
         for (int a = 0; a < 3 && st == ST_OK; a++) begin
            mag = d[a] < 0 ? -d[a] : d[a];
            if (mag <= peps) begin
               if (o[a] < lo[a] || o[a] > hi[a]) st = ST_MISS;
            end else begin
               t0 = clip32(((lo[a] - o[a]) * 65536) / d[a]);
               t1 = clip32(((hi[a] - o[a]) * 65536) / d[a]);
               if (t0 > t1) begin
                  t = t0; t0 = t1; t1 = t;
               end
               if (t0 > tmin) tmin = t0;
               if (t1 < tmax) tmax = t1;
               if (tmin > tmax) st = ST_MISS;
            end
         end
         if (st == ST_OK && !(tmax > deps)) st = ST_BEHIND;
         if (st == ST_OK) begin
            lower = tmin > deps ? tmin : deps;
            if (fdist < lower) fdist = lower;
            if (fdist > tmax) fdist = tmax;
            if (!(fdist > deps)) st = ST_DEGEN;
         end
         if (st == ST_OK) begin
            res.focus_x = 32'(clip32(o[0] + fl_shr(d[0] * fdist, FRAC_BITS)));
            res.focus_y = 32'(clip32(o[1] + fl_shr(d[1] * fdist, FRAC_BITS)));
            res.focus_z = 32'(clip32(o[2] + fl_shr(d[2] * fdist, FRAC_BITS)));
         end
      end
      res.status = st;
      return res;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(3);
      return $urandom_range(40, 8);
   endfunction

   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr;
      csr_pwdata <= {16'd0, value}; csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == ADDR_PAR_EPS) par_eps = value;
      else dist_eps = value;
   endtask

   task automatic drain();
      while (focus_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);
   endtask

   // Drive one ray; the expectation is queued when the handshake completes.
   task automatic send_ray(rbfp_req_type r, logic [2:0] typed_st);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      focus_q.push_back(focus_of(r));
      typed_q.push_back(typed_st);
   endtask

   function automatic logic signed [31:0] rnd_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
         2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed($urandom_range(65536 * 8)) - 32'sd262144;
      endcase
   endfunction

   function automatic logic signed [17:0] rnd_dir();
      case ($urandom_range(4))
         0: return 18'($urandom);
         1: return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
         2: return $signed(18'($urandom_range(40))) - 18'sd20;
         default: return $signed(18'($urandom_range(131072))) - 18'sd65536;
      endcase
   endfunction

   function automatic rbfp_req_type rnd_ray();
      rbfp_req_type r;
      logic signed [31:0] a, b;
      r = '0;
      r.origin_x = rnd_coord(); r.origin_y = rnd_coord(); r.origin_z = rnd_coord();
      r.dir_x = rnd_dir(); r.dir_y = rnd_dir(); r.dir_z = rnd_dir();
      for (int k = 0; k < 3; k++) begin
         a = rnd_coord(); b = rnd_coord();
         // keep most boxes well formed
         if ($urandom_range(9) != 0 && a > b) begin
            a ^= b; b ^= a; a ^= b;
         end
         case (k)
            0: begin r.box_min_x = a; r.box_max_x = b; end
            1: begin r.box_min_y = a; r.box_max_y = b; end
            default: begin r.box_min_z = a; r.box_max_z = b; end
         endcase
      end
      // place the origin just outside the box's min corner now and then
      if ($urandom_range(2) == 0) begin
         r.origin_x = r.box_min_x - 32'sd1048576;
         r.origin_y = r.box_min_y;
         r.origin_z = r.box_min_z;
      end
      return r;
   endfunction

   function automatic rbfp_req_type mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                       int lx, int ly, int lz, int hx, int hy, int hz);
      rbfp_req_type r;
      r = '0;
      r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
      r.dir_x = 18'(dx); r.dir_y = 18'(dy); r.dir_z = 18'(dz);
      r.box_min_x = lx; r.box_min_y = ly; r.box_min_z = lz;
      r.box_max_x = hx; r.box_max_y = hy; r.box_max_z = hz;
      return r;
   endfunction

   typedef struct {
      rbfp_req_type ray;
      logic [2:0]   st;
   } ray_row_type;

   localparam int ONE = 65536;
   localparam int IMAX = 32'h7FFFFFFF;
   localparam int IMIN = 32'h80000000;

   initial begin
      ray_row_type rows[$];
      rows.push_back('{mk(0,0,0, ONE,0,0, ONE,-ONE,-ONE, 3*ONE,ONE,ONE), ST_OK});
      rows.push_back('{mk(0,0,0, ONE,0,0, 5,0,0, 4,0,0), ST_INV});
      rows.push_back('{mk(0,0,0, 0,ONE,0, 0,0,0, 0,0,-1), ST_INV});
      rows.push_back('{mk(0,0,0, ONE,0,0, ONE,2*ONE,-ONE, 3*ONE,3*ONE,ONE), ST_MISS});
      rows.push_back('{mk(0,0,0, ONE,0,0, -3*ONE,-ONE,-ONE, -ONE,ONE,ONE), ST_MISS});
      rows.push_back('{mk(0,0,0, -ONE,0,0, ONE,-ONE,-ONE, 3*ONE,ONE,ONE), ST_MISS});
      rows.push_back('{mk(0,0,0, ONE,ONE,0, ONE,-3*ONE,-ONE, 2*ONE,-2*ONE,ONE), ST_MISS});
      rows.push_back('{mk(0,0,0, ONE,0,0, -ONE,-ONE,-ONE, 0,ONE,ONE), ST_BEHIND});
      rows.push_back('{mk(IMIN,IMIN,IMIN, ONE,ONE,ONE, IMIN,IMIN,IMIN, IMAX,IMAX,IMAX),
                       NO_CHECK});
      rows.push_back('{mk(IMAX,IMAX,IMAX, -ONE,-ONE,-ONE, IMIN,IMIN,IMIN, IMAX,IMAX,IMAX),
                       NO_CHECK});
      rows.push_back('{mk(0,0,0, -ONE,-ONE,-ONE, IMIN,IMIN,IMIN, IMAX,IMAX,IMAX), NO_CHECK});
      rows.push_back('{mk(0,0,0, 1,-1,-131072, -ONE,-ONE,-ONE, ONE,ONE,ONE), NO_CHECK});
      rows.push_back('{mk(0,0,0, 131071,131071,131071, 1,1,1, IMAX,IMAX,IMAX), NO_CHECK});
      rows.push_back('{mk(0,0,0, 0,0,0, -1,-1,-1, 1,1,1), NO_CHECK});
      rows.push_back('{mk(0,0,0, 0,0,0, 1,1,1, 2,2,2), ST_MISS});
      rows.push_back('{mk(-1,-1,-1, ONE,ONE,ONE, IMIN,IMIN,IMIN, -1,-1,-1), NO_CHECK});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      par_eps = 16'd0;
      dist_eps = 16'd1;
      foreach (rows[i]) send_ray(rows[i].ray, rows[i].st);
      req_tvalid <= 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         case (ph)
            0: begin csr_write(ADDR_PAR_EPS, 16'hFFFF); csr_write(ADDR_DIST_EPS, 16'h0000); end
            1: begin csr_write(ADDR_PAR_EPS, 16'd16);   csr_write(ADDR_DIST_EPS, 16'hFFFF); end
            2: begin
               csr_write(ADDR_PAR_EPS, 16'($urandom));
               csr_write(ADDR_DIST_EPS, 16'($urandom));
            end
            3: begin csr_write(ADDR_PAR_EPS, 16'd0);    csr_write(ADDR_DIST_EPS, 16'd1); end
            default: begin csr_write(ADDR_PAR_EPS, 16'd4); csr_write(ADDR_DIST_EPS, 16'd256); end
         endcase
         for (int n = 0; n < RANDOM_RAYS / 5; n++) send_ray(rnd_ray(), NO_CHECK);
         req_tvalid <= 1'b0;
      end
      drain();
      feeding = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(9) < 7) || (gap_len() == 0);
   end

   always @(posedge clock) begin
      rbfp_rsp_type got, want;
      logic [2:0] typed;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (focus_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = focus_q.pop_front();
            typed = typed_q.pop_front();
            if (got.focus_x !== want.focus_x || got.focus_y !== want.focus_y ||
                got.focus_z !== want.focus_z || got.status !== want.status ||
                (typed != NO_CHECK && got.status !== typed)) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: want %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                           want.focus_x, want.focus_y, want.focus_z, want.status,
                           got.focus_x, got.focus_y, got.focus_z, got.status);
            end
         end
      end
   end

   initial begin
      wait (!feeding || cycles >= LIMIT);
      if (cycles >= LIMIT) begin
         $display("tb_top: errors");
      end else if (errors == 0 && focus_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/rbfp_pkg.sv
rtl/rbfp_div.sv
rtl/rbfp_front.sv
rtl/rbfp_back.sv
rtl/ray_box_focus_point.sv
rtl/rbfp_check.sv
tb/sv/tb_top.sv
